// ===== src/rus_pkg.sv =====
// ----------------------------------------------------------------------------
// rus_pkg
// Shared codes and types of the recycled uniform sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package rus_pkg;

  localparam int unsigned EntropyBits = 64;

  localparam logic [3:0] OP_ENTROPY    = 4'd0;
  localparam logic [3:0] OP_RAW        = 4'd1;
  localparam logic [3:0] OP_UNIFORM    = 4'd2;
  localparam logic [3:0] OP_BITS       = 4'd3;
  localparam logic [3:0] OP_U32        = 4'd4;
  localparam logic [3:0] OP_PREDIV     = 4'd5;
  localparam logic [3:0] OP_BERN       = 4'd6;
  localparam logic [3:0] OP_BERN2DIV   = 4'd7;
  localparam logic [3:0] OP_MERGE      = 4'd8;
  localparam logic [3:0] OP_MERGE_BITS = 4'd9;

  localparam logic [1:0] REG_OUTCOMES = 2'd0;
  localparam logic [1:0] REG_QUOTIENT = 2'd1;
  localparam logic [1:0] REG_NOTREM   = 2'd2;
  localparam logic [1:0] REG_INVERSE  = 2'd3;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_ACCEPT,
    CMD_SETUP,
    CMD_STALL,
    CMD_TAKE1,
    CMD_SHIFT9,
    CMD_CLZ_INIT,
    CMD_CLZ_STEP,
    CMD_SHIFTIN,
    CMD_DIV_GO,
    CMD_DRAW_EVAL,
    CMD_MUL_TB,
    CMD_ST_TB,
    CMD_MUL_FB,
    CMD_BERN_EVAL,
    CMD_RES_R,
    CMD_MUL_P,
    CMD_ST_HI,
    CMD_MUL_INV,
    CMD_INV_SET,
    CMD_B7_SET,
    CMD_MUL_UB,
    CMD_ST_UB,
    CMD_MUL_UV,
    CMD_ST_UV,
    CMD_DONE,
    CMD_BUSYOUT
  } rus_cmd_e;

  typedef struct packed {
    logic [3:0] work_op;
    logic       pend_valid;
    logic       skip;
    logic       take_ok;
    logic       renorm_need;
    logic       renorm_ok;
    logic       clz_hit;
    logic       div_done;
    logic       mul_done;
    logic       draw_ok;
    logic       bern_done;
    logic       p_reject;
    logic       out_free;
  } rus_status_t;

endpackage

`default_nettype wire

// ===== src/rus_div.sv =====
// ----------------------------------------------------------------------------
// rus_div
// Restoring 64-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rus_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [63:0] divisor_i,
  output logic      [63:0] quot_o,
  output logic      [63:0] rem_o,
  output logic             done_o
);

  logic [63:0] quot_q, rem_q, dsr_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] rem_sh, rem_nx;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, quot_q[63]};
    ge     = rem_sh >= {1'b0, dsr_q};
    rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[62:0], ge};
      rem_q  <= rem_nx[63:0];
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== src/rus_mul.sv =====
// ----------------------------------------------------------------------------
// rus_mul
// 64 x 64 multiplier, low 64 bits, from three 32 x 32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module rus_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] prod_o,
  output logic             done_o
);

  logic [63:0] a_q, b_q, acc_q;
  logic [1:0]  step_q;
  logic        done_q;
  logic [31:0] x, y;
  logic [63:0] pp;

  always_comb begin
    x  = (step_q == 2'd3) ? a_q[63:32] : a_q[31:0];
    y  = (step_q == 2'd2) ? b_q[63:32] : b_q[31:0];
    pp = x * y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= 2'd1;
      end else if (step_q == 2'd3) begin
        step_q <= 2'd0;
        done_q <= 1'b1;
      end else if (step_q != 2'd0) begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (step_q == 2'd1) begin
      acc_q <= pp;
    end else if (step_q != 2'd0) begin
      acc_q <= acc_q + {pp[31:0], 32'd0};
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== src/rus_dp.sv =====
// ----------------------------------------------------------------------------
// rus_dp
// Datapath: uniform pair, entropy buffer, pending request, config and
// output registers, with the divider pair and the multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rus_dp #(
  parameter int unsigned RenormMinShift = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rus_pkg::rus_cmd_e   cmd_i,
  output rus_pkg::rus_status_t     stat_o,
  input  wire logic [3:0]          op_i,
  input  wire logic [63:0]         operand_a_i,
  input  wire logic [63:0]         operand_b_i,
  input  wire logic [63:0]         entropy_word_i,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [63:0]         cfg_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [63:0]              value_o,
  output logic                     status_o
);

  import rus_pkg::*;

  localparam logic [63:0] DivLimit  = 64'd1 << (64 - RenormMinShift);
  localparam logic [63:0] MaxBitsOp = 64'(64 - RenormMinShift);
  localparam bit          U32Skip   = (RenormMinShift > 32);
  localparam logic [6:0]  MinShift  = 7'(RenormMinShift);
  localparam logic [6:0]  Full      = 7'(EntropyBits);

  function automatic logic [2:0] clz8(input logic [7:0] x);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) n = 3'(7 - i);
    end
    return n;
  endfunction

  // architectural state
  logic [63:0] uv_q, ub_q, ecur_q, espare_q;
  logic [6:0]  eleft_q;
  logic        svalid_q, pvalid_q;
  logic [31:0] outcomes_q, quotient_q, notrem_q;
  logic [63:0] inverse_q;
  logic        out_valid_q;
  // request working set
  logic [3:0]  pop_q, wop_q;
  logic [63:0] pa_q, pb_q, wa_q, wb_q;
  logic [63:0] d_q, numer_q, mm_q, mv_q, r_q, tb_q, res_q, scan_q;
  logic [31:0] hi_q;
  logic [6:0]  cnt_q, k_q;
  logic [63:0] out_value_q;
  logic        out_status_q;

  // entropy take
  logic [6:0]   n_take, k_sel, tk_l, eleft_n;
  logic [7:0]   avail_total, tk_sh;
  logic [63:0]  tk_cur, tk_mask, take_val, ecur_n;
  logic [191:0] tk_word;
  logic         tk_sv, svalid_n;

  // arithmetic units
  logic [63:0] qs, rs, qb, rb, mul_p, mul_a, mul_b;
  logic        div_a_done, div_b_done, div_start, mul_start, mul_done;
  logic        skip;

  always_comb begin
    n_take      = (wa_q > 64'd64) ? Full : wa_q[6:0];
    avail_total = {1'b0, eleft_q} + (svalid_q ? 8'(EntropyBits) : 8'd0);
    k_sel       = (cmd_i == CMD_SHIFTIN) ? k_q : n_take;
    tk_cur      = (eleft_q == '0) ? espare_q : ecur_q;
    tk_l        = (eleft_q == '0) ? Full : eleft_q;
    tk_sv       = (eleft_q == '0) ? 1'b0 : svalid_q;
    tk_word     = {64'd0, tk_cur, espare_q};
    tk_sh       = 8'(EntropyBits) + {1'b0, tk_l} - {1'b0, k_sel};
    tk_mask     = (k_sel == Full) ? '1 : ((64'd1 << k_sel[5:0]) - 64'd1);
    take_val    = tk_word[tk_sh[6:0] +: 64] & tk_mask;
    if (k_sel <= tk_l) begin
      ecur_n   = tk_cur;
      eleft_n  = tk_l - k_sel;
      svalid_n = tk_sv;
    end else begin
      ecur_n   = espare_q;
      eleft_n  = 7'(8'(EntropyBits) + {1'b0, tk_l} - {1'b0, k_sel});
      svalid_n = 1'b0;
    end
  end

  always_comb begin
    case (wop_q)
      OP_RAW:                  skip = (wa_q == '0);
      OP_UNIFORM:              skip = (wa_q == '0) || (wa_q > DivLimit);
      OP_BITS:                 skip = (wa_q > MaxBitsOp);
      OP_U32, OP_PREDIV:       skip = U32Skip;
      OP_BERN, OP_BERN2DIV:    skip = (wb_q == '0) || (wb_q > DivLimit);
      default:                 skip = 1'b0;
    endcase
  end

  always_comb begin
    mul_start = 1'b1;
    mul_a     = uv_q;
    mul_b     = mm_q;
    case (cmd_i)
      CMD_MUL_TB:  begin mul_a = qb;        mul_b = numer_q;              end
      CMD_MUL_FB:  begin mul_a = qb;        mul_b = d_q;                  end
      CMD_MUL_P:   begin mul_a = r_q;       mul_b = {32'd0, outcomes_q};  end
      CMD_MUL_INV: begin mul_a = inverse_q; mul_b = {32'd0, hi_q};        end
      CMD_MUL_UB:  begin mul_a = ub_q;      mul_b = mm_q;                 end
      CMD_MUL_UV:  begin mul_a = uv_q;      mul_b = mm_q;                 end
      default:     mul_start = 1'b0;
    endcase
  end

  assign div_start = (cmd_i == CMD_DIV_GO);

  rus_div u_div_value (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(uv_q), .divisor_i(d_q),
    .quot_o(qs), .rem_o(rs), .done_o(div_a_done)
  );

  rus_div u_div_bound (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(ub_q), .divisor_i(d_q),
    .quot_o(qb), .rem_o(rb), .done_o(div_b_done)
  );

  rus_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .prod_o(mul_p), .done_o(mul_done)
  );

  always_comb begin
    stat_o.work_op     = wop_q;
    stat_o.pend_valid  = pvalid_q;
    stat_o.skip        = skip;
    stat_o.take_ok     = {1'b0, n_take} <= avail_total;
    stat_o.renorm_need = k_q >= MinShift;
    stat_o.renorm_ok   = {1'b0, k_q} <= avail_total;
    stat_o.clz_hit     = scan_q[63:56] != 8'd0;
    stat_o.div_done    = div_a_done & div_b_done;
    stat_o.mul_done    = mul_done;
    stat_o.draw_ok     = qs < qb;
    stat_o.bern_done   = (uv_q < tb_q) || (uv_q < mul_p);
    stat_o.p_reject    = mul_p[31:0] > notrem_q;
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uv_q        <= 64'd0;
      ub_q        <= 64'd1;
      ecur_q      <= '0;
      espare_q    <= '0;
      eleft_q     <= '0;
      svalid_q    <= 1'b0;
      pvalid_q    <= 1'b0;
      outcomes_q  <= 32'd2;
      quotient_q  <= 32'h8000_0000;
      notrem_q    <= 32'hFFFF_FFFF;
      inverse_q   <= 64'h8000_0000_0000_0000;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_OUTCOMES: outcomes_q <= cfg_data_i[31:0];
          REG_QUOTIENT: quotient_q <= cfg_data_i[31:0];
          REG_NOTREM:   notrem_q   <= cfg_data_i[31:0];
          REG_INVERSE:  inverse_q  <= cfg_data_i;
          default:      ;
        endcase
      end
      if (cmd_i == CMD_DONE || cmd_i == CMD_BUSYOUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i)
        CMD_ACCEPT: begin
          if (op_i == OP_ENTROPY) begin
            if (eleft_q == '0) begin
              eleft_q <= Full;
              if (svalid_q) begin
                ecur_q   <= espare_q;
                espare_q <= entropy_word_i;
              end else begin
                ecur_q <= entropy_word_i;
              end
            end else if (!svalid_q) begin
              espare_q <= entropy_word_i;
              svalid_q <= 1'b1;
            end
          end
        end
        CMD_STALL: pvalid_q <= 1'b1;
        CMD_TAKE1: begin
          ecur_q   <= ecur_n;
          eleft_q  <= eleft_n;
          svalid_q <= svalid_n;
        end
        CMD_SHIFTIN: begin
          ecur_q   <= ecur_n;
          eleft_q  <= eleft_n;
          svalid_q <= svalid_n;
          ub_q     <= ub_q << k_q[5:0];
          uv_q     <= (uv_q << k_q[5:0]) | take_val;
        end
        CMD_SHIFT9: begin
          if (wb_q >= 64'd64) begin
            ub_q <= '0;
            uv_q <= wa_q;
          end else begin
            ub_q <= ub_q << wb_q[5:0];
            uv_q <= (uv_q << wb_q[5:0]) | wa_q;
          end
        end
        CMD_CLZ_INIT: begin
          if (ub_q == '0) begin
            ub_q <= 64'd1;
            uv_q <= '0;
          end
        end
        CMD_DRAW_EVAL: begin
          if (qs < qb) begin
            uv_q <= qs;
            ub_q <= qb;
          end else begin
            uv_q <= rs;
            ub_q <= rb;
          end
        end
        CMD_BERN_EVAL: begin
          if (uv_q < tb_q) begin
            ub_q <= tb_q;
          end else if (uv_q < mul_p) begin
            uv_q <= uv_q - tb_q;
            ub_q <= mul_p - tb_q;
          end else begin
            uv_q <= uv_q - mul_p;
            ub_q <= rb;
          end
        end
        CMD_ST_UB: ub_q <= mul_p;
        CMD_ST_UV: uv_q <= mul_p + mv_q;
        CMD_DONE:  pvalid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_ACCEPT: begin
        if (op_i == OP_ENTROPY) begin
          wop_q <= pop_q;
          wa_q  <= pa_q;
          wb_q  <= pb_q;
        end else begin
          wop_q <= op_i;
          wa_q  <= operand_a_i;
          wb_q  <= operand_b_i;
        end
      end
      CMD_SETUP: begin
        case (wop_q)
          OP_UNIFORM:           d_q <= wa_q;
          OP_BITS:              d_q <= 64'd1 << wa_q[5:0];
          OP_BERN, OP_BERN2DIV: d_q <= wb_q;
          default:              d_q <= 64'd1 << 32;
        endcase
        numer_q <= (wa_q > wb_q) ? wb_q : wa_q;
        mm_q    <= wb_q;
        mv_q    <= wa_q;
        res_q   <= '0;
      end
      CMD_STALL: begin
        pop_q <= wop_q;
        pa_q  <= wa_q;
        pb_q  <= wb_q;
      end
      CMD_TAKE1: res_q <= take_val;
      CMD_CLZ_INIT: begin
        scan_q <= (ub_q == '0) ? 64'd1 : ub_q;
        cnt_q  <= '0;
      end
      CMD_CLZ_STEP: begin
        if (scan_q[63:56] == 8'd0) begin
          scan_q <= scan_q << 8;
          cnt_q  <= cnt_q + 7'd8;
        end else begin
          k_q <= cnt_q + {4'd0, clz8(scan_q[63:56])};
        end
      end
      CMD_DRAW_EVAL: if (qs < qb) r_q <= rs;
      CMD_ST_TB:     tb_q <= mul_p;
      CMD_BERN_EVAL: res_q <= (uv_q < tb_q) ? 64'd1 : 64'd0;
      CMD_RES_R:     res_q <= r_q;
      CMD_ST_HI: begin
        hi_q  <= mul_p[63:32];
        res_q <= {32'd0, mul_p[63:32]};
      end
      CMD_INV_SET: begin
        mv_q <= {32'd0, r_q[31:0] - mul_p[63:32]};
        mm_q <= {32'd0, quotient_q};
      end
      CMD_B7_SET: begin
        if (r_q < numer_q) begin
          mv_q  <= r_q;
          mm_q  <= numer_q;
          res_q <= 64'd1;
        end else begin
          mv_q  <= r_q - numer_q;
          mm_q  <= wb_q - numer_q;
        end
      end
      CMD_DONE: begin
        out_value_q  <= res_q;
        out_status_q <= 1'b0;
      end
      CMD_BUSYOUT: begin
        out_value_q  <= '0;
        out_status_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

endmodule

`default_nettype wire

// ===== src/rus_ctrl.sv =====
// ----------------------------------------------------------------------------
// rus_ctrl
// Request sequencer: renormalize, divide, evaluate, merge, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module rus_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [3:0]     op_i,
  input  wire rus_pkg::rus_status_t st_i,
  output rus_pkg::rus_cmd_e   cmd_o
);

  import rus_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SETUP = 5'd1;
  localparam logic [4:0] S_TAKE  = 5'd2;
  localparam logic [4:0] S_SH9   = 5'd3;
  localparam logic [4:0] S_STALL = 5'd4;
  localparam logic [4:0] S_CLZI  = 5'd5;
  localparam logic [4:0] S_CLZS  = 5'd6;
  localparam logic [4:0] S_RCHK  = 5'd7;
  localparam logic [4:0] S_DIVGO = 5'd8;
  localparam logic [4:0] S_DIVW  = 5'd9;
  localparam logic [4:0] S_MTB   = 5'd10;
  localparam logic [4:0] S_WTB   = 5'd11;
  localparam logic [4:0] S_MFB   = 5'd12;
  localparam logic [4:0] S_WFB   = 5'd13;
  localparam logic [4:0] S_BEVAL = 5'd14;
  localparam logic [4:0] S_POST  = 5'd15;
  localparam logic [4:0] S_WP    = 5'd16;
  localparam logic [4:0] S_MINV  = 5'd17;
  localparam logic [4:0] S_WINV  = 5'd18;
  localparam logic [4:0] S_MUB   = 5'd19;
  localparam logic [4:0] S_WUB   = 5'd20;
  localparam logic [4:0] S_MUV   = 5'd21;
  localparam logic [4:0] S_WUV   = 5'd22;
  localparam logic [4:0] S_FIN   = 5'd23;
  localparam logic [4:0] S_FINB  = 5'd24;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o = CMD_ACCEPT;
          if (op_i == OP_ENTROPY) begin
            if (st_i.pend_valid) state_d = S_SETUP;
          end else if (op_i <= OP_MERGE_BITS) begin
            state_d = st_i.pend_valid ? S_FINB : S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd_o = CMD_SETUP;
        if (st_i.skip) state_d = S_FIN;
        else begin
          case (st_i.work_op)
            OP_RAW:        state_d = st_i.take_ok ? S_TAKE : S_STALL;
            OP_MERGE:      state_d = S_MUB;
            OP_MERGE_BITS: state_d = S_SH9;
            default:       state_d = S_CLZI;
          endcase
        end
      end
      S_TAKE: begin
        cmd_o   = CMD_TAKE1;
        state_d = S_FIN;
      end
      S_SH9: begin
        cmd_o   = CMD_SHIFT9;
        state_d = S_FIN;
      end
      S_STALL: begin
        cmd_o   = CMD_STALL;
        state_d = S_IDLE;
      end
      S_CLZI: begin
        cmd_o   = CMD_CLZ_INIT;
        state_d = S_CLZS;
      end
      S_CLZS: begin
        cmd_o = CMD_CLZ_STEP;
        if (st_i.clz_hit) state_d = S_RCHK;
      end
      S_RCHK: begin
        if (!st_i.renorm_need) state_d = S_DIVGO;
        else if (st_i.renorm_ok) begin
          cmd_o   = CMD_SHIFTIN;
          state_d = S_DIVGO;
        end else state_d = S_STALL;
      end
      S_DIVGO: begin
        cmd_o   = CMD_DIV_GO;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (st_i.div_done) begin
          if (st_i.work_op == OP_BERN) state_d = S_MTB;
          else begin
            cmd_o   = CMD_DRAW_EVAL;
            state_d = st_i.draw_ok ? S_POST : S_CLZI;
          end
        end
      end
      S_MTB: begin
        cmd_o   = CMD_MUL_TB;
        state_d = S_WTB;
      end
      S_WTB: begin
        if (st_i.mul_done) begin
          cmd_o   = CMD_ST_TB;
          state_d = S_MFB;
        end
      end
      S_MFB: begin
        cmd_o   = CMD_MUL_FB;
        state_d = S_WFB;
      end
      S_WFB: if (st_i.mul_done) state_d = S_BEVAL;
      S_BEVAL: begin
        cmd_o   = CMD_BERN_EVAL;
        state_d = st_i.bern_done ? S_FIN : S_CLZI;
      end
      S_POST: begin
        case (st_i.work_op)
          OP_PREDIV: begin
            cmd_o   = CMD_MUL_P;
            state_d = S_WP;
          end
          OP_BERN2DIV: begin
            cmd_o   = CMD_B7_SET;
            state_d = S_MUB;
          end
          default: begin
            cmd_o   = CMD_RES_R;
            state_d = S_FIN;
          end
        endcase
      end
      S_WP: begin
        if (st_i.mul_done) begin
          if (st_i.p_reject) state_d = S_CLZI;
          else begin
            cmd_o   = CMD_ST_HI;
            state_d = S_MINV;
          end
        end
      end
      S_MINV: begin
        cmd_o   = CMD_MUL_INV;
        state_d = S_WINV;
      end
      S_WINV: begin
        if (st_i.mul_done) begin
          cmd_o   = CMD_INV_SET;
          state_d = S_MUB;
        end
      end
      S_MUB: begin
        cmd_o   = CMD_MUL_UB;
        state_d = S_WUB;
      end
      S_WUB: begin
        if (st_i.mul_done) begin
          cmd_o   = CMD_ST_UB;
          state_d = S_MUV;
        end
      end
      S_MUV: begin
        cmd_o   = CMD_MUL_UV;
        state_d = S_WUV;
      end
      S_WUV: begin
        if (st_i.mul_done) begin
          cmd_o   = CMD_ST_UV;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (st_i.out_free) begin
          cmd_o   = CMD_DONE;
          state_d = S_IDLE;
        end
      end
      S_FINB: begin
        if (st_i.out_free) begin
          cmd_o   = CMD_BUSYOUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_i.div_done |-> state_q == S_DIVW)
    else $error("divider finished outside its wait state");

  a_mul_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_i.mul_done |-> (state_q == S_WTB || state_q == S_WFB || state_q == S_WP ||
                       state_q == S_WINV || state_q == S_WUB || state_q == S_WUV))
    else $error("multiplier finished outside a wait state");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_DONE || cmd_o == CMD_BUSYOUT) |-> st_i.out_free)
    else $error("result loaded over an untaken result");

  a_entropy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_i == OP_ENTROPY && !st_i.pend_valid)
      |=> state_q == S_IDLE)
    else $error("entropy transfer without pending request left idle");
`endif

endmodule

`default_nettype wire

// ===== src/recycled_uniform_sampler_top.sv =====
// ----------------------------------------------------------------------------
// recycled_uniform_sampler_top
// Uniform and Bernoulli sampler that recycles leftover randomness.
//
// Input channel (in_valid_i/in_ready_o) takes one request per transfer:
// op 0 supplies a 64-bit entropy word, ops 1..9 sample or merge. Output
// channel (out_valid_o/out_ready_i) returns value_o and status_o.
// One request is worked on at a time; in_ready_o is high only when the
// sequencer is idle. A finished result sits in the output register, so a
// new request is taken while the receiver stalls; the next result waits
// until that register frees.
// A raw-bit or merge request skips the draw iteration. Each draw iteration
// runs a leading-zero scan and then the bit-serial dividers (both quotients
// at once); Bernoulli adds two multiplies, a merge two more. Rejected draws
// repeat the iteration.
// A request that runs out of entropy produces no result; it resumes when an
// entropy word arrives. A request arriving while one is parked gets value 0
// with status 1. Reset clears the pair to (0, 1), empties the entropy
// buffer, drops any parked request and loads the default config.
// ----------------------------------------------------------------------------
`default_nettype none

module recycled_uniform_sampler_top #(
  parameter int unsigned RenormMinShift = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  op_i,
  input  wire logic [63:0] operand_a_i,
  input  wire logic [63:0] operand_b_i,
  input  wire logic [63:0] entropy_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      value_o,
  output logic             status_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  import rus_pkg::*;

  rus_cmd_e    cmd;
  rus_status_t st;

  rus_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i,
    .st_i(st), .cmd_o(cmd)
  );

  rus_dp #(.RenormMinShift(RenormMinShift)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(st),
    .op_i, .operand_a_i, .operand_b_i, .entropy_word_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .out_valid_o, .out_ready_i, .value_o, .status_o
  );

endmodule

`default_nettype wire
